// ===== rtl/glrc_pkg.sv =====
package glrc_pkg;

  // default sizes
  localparam int DEF_MAX_NODES  = 1024;
  localparam int DEF_MAX_LABELS = 1024;
  localparam int DEF_FRAC_BITS  = 32;

  // fixed field widths
  localparam int IDX_W   = 10;
  localparam int OFF_W   = 32;
  localparam int LABEL_W = 11;
  localparam int CMP_W   = 17;

  // command codes
  typedef enum logic [1:0] {
    CMD_LOAD_OFFSET = 2'd0,
    CMD_LOAD_NODE   = 2'd1,
    CMD_EDGE        = 2'd2,
    CMD_COMPRESS    = 2'd3
  } cmd_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_E_LAB,
    ST_E_OFF,
    ST_C_CHK,
    ST_C_CMP
  } state_t;

endpackage

// ===== rtl/graph_label_refine_compress.sv =====
// load items write their memory on accept; edge items step through label read, offset read, add and write back
// compress: ST_C_CHK and ST_C_CMP alternate over the distinct entries until a match or the table fill
// one item at a time (in_ready needs an idle sequencer and no pending result); paced by the single compare
// reset (rst_n low, synchronous): sequencer idle, no result pending, distinct table empty
// memories hold no reset value; entries are defined once written
module graph_label_refine_compress #(
  parameter int MAX_NODES  = glrc_pkg::DEF_MAX_NODES,
  parameter int MAX_LABELS = glrc_pkg::DEF_MAX_LABELS,
  parameter int FRAC_BITS  = glrc_pkg::DEF_FRAC_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_command,
  input  logic [glrc_pkg::IDX_W-1:0]  in_node_index,
  input  logic [glrc_pkg::IDX_W-1:0]  in_neighbor_node,
  input  logic [glrc_pkg::IDX_W-1:0]  in_label_value,
  input  logic [glrc_pkg::OFF_W-1:0]  in_offset_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [glrc_pkg::LABEL_W-1:0] out_new_label,
  output logic                        out_table_overflow
);
  import glrc_pkg::*;

  localparam int NAW = $clog2(MAX_NODES);
  localparam int LAW = $clog2(MAX_LABELS);
  localparam int CW  = $clog2(MAX_NODES + 1);
  localparam int SW  = 16 + FRAC_BITS;
  localparam int SHL = (FRAC_BITS >= 32) ? FRAC_BITS - 32 : 0;
  localparam int SHR = (FRAC_BITS < 32) ? 32 - FRAC_BITS : 0;

  // storage
  logic [OFF_W-1:0] offset_mem [MAX_LABELS];
  logic [IDX_W-1:0] label_mem  [MAX_NODES];
  logic [SW-1:0]    sig_mem    [MAX_NODES];
  logic [SW-1:0]    dist_mem   [MAX_NODES];

  logic [OFF_W-1:0] off_q;
  logic [IDX_W-1:0] lab_q;
  logic [SW-1:0]    sig_q;
  logic [SW-1:0]    dist_q;

  state_t           state_r, state_nxt;
  logic [NAW-1:0]   node_r, node_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [LABEL_W-1:0] out_label_r, out_label_nxt;
  logic             out_ovf_r, out_ovf_nxt;

  logic             accept;
  cmd_t             cmd;
  logic             node_ok, nb_ok, lab_ok;
  logic [SW-1:0]    scaled_off;
  logic [SW-1:0]    sig_sum;
  logic [SW-1:0]    sig_init;
  logic             sig_we, dist_we, off_we, lab_we;
  logic [NAW-1:0]   sig_ra, sig_wa;
  logic [SW-1:0]    sig_wd;

  assign accept   = in_valid && in_ready;
  assign cmd      = cmd_t'(in_command);
  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;

  // range checks
  assign node_ok = CMP_W'(in_node_index) < CMP_W'(MAX_NODES);
  assign nb_ok   = CMP_W'(in_neighbor_node) < CMP_W'(MAX_NODES);
  assign lab_ok  = (lab_q != '0) && (CMP_W'(lab_q) < CMP_W'(MAX_LABELS));

  // fixed point alignment
  assign scaled_off = SW'((64'(off_q) >> SHR) << SHL);
  assign sig_sum    = sig_q + scaled_off;
  assign sig_init   = SW'(64'(in_label_value) << FRAC_BITS);

  // memory port control
  assign off_we  = accept && (cmd == CMD_LOAD_OFFSET) &&
                   (CMP_W'(in_node_index) < CMP_W'(MAX_LABELS));
  assign lab_we  = accept && (cmd == CMD_LOAD_NODE) && node_ok;
  assign sig_we  = lab_we || (state_r == ST_E_OFF);
  assign sig_wa  = (state_r == ST_E_OFF) ? node_r : NAW'(in_node_index);
  assign sig_wd  = (state_r == ST_E_OFF) ? sig_sum : sig_init;
  assign sig_ra  = accept ? NAW'(in_node_index) : node_r;
  assign dist_we = (state_r == ST_C_CHK) && (idx_r == count_r) &&
                   (count_r < CW'(MAX_NODES));

  always_ff @(posedge clk) begin
    if (off_we) begin
      offset_mem[LAW'(in_node_index)] <= in_offset_value;
    end
    off_q <= offset_mem[LAW'(lab_q)];
  end

  always_ff @(posedge clk) begin
    if (lab_we) begin
      label_mem[NAW'(in_node_index)] <= in_label_value;
    end
    lab_q <= label_mem[NAW'(in_neighbor_node)];
  end

  always_ff @(posedge clk) begin
    if (sig_we) begin
      sig_mem[sig_wa] <= sig_wd;
    end
    sig_q <= sig_mem[sig_ra];
  end

  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[NAW'(count_r)] <= sig_q;
    end
    dist_q <= dist_mem[NAW'(idx_r)];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && node_ok) begin
          if (cmd == CMD_EDGE && nb_ok) begin
            state_nxt = ST_E_LAB;
          end else if (cmd == CMD_COMPRESS) begin
            state_nxt = ST_C_CHK;
          end
        end
      end
      ST_E_LAB: state_nxt = lab_ok ? ST_E_OFF : ST_IDLE;
      ST_E_OFF: state_nxt = ST_IDLE;
      ST_C_CHK: state_nxt = (idx_r == count_r) ? ST_IDLE : ST_C_CMP;
      ST_C_CMP: state_nxt = (dist_q == sig_q) ? ST_IDLE : ST_C_CHK;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and result register
  always_comb begin
    node_nxt      = node_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_label_nxt = out_label_r;
    out_ovf_nxt   = out_ovf_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          node_nxt = NAW'(in_node_index);
          idx_nxt  = '0;
          if (lab_we) begin
            count_nxt = '0;
          end
        end
      end
      ST_C_CHK: begin
        if (idx_r == count_r) begin
          out_valid_nxt = 1'b1;
          if (count_r < CW'(MAX_NODES)) begin
            count_nxt     = count_r + 1'b1;
            out_label_nxt = LABEL_W'(count_r + 1'b1);
            out_ovf_nxt   = 1'b0;
          end else begin
            out_label_nxt = '0;
            out_ovf_nxt   = 1'b1;
          end
        end
      end
      ST_C_CMP: begin
        if (dist_q == sig_q) begin
          out_valid_nxt = 1'b1;
          out_label_nxt = LABEL_W'(idx_r + 1'b1);
          out_ovf_nxt   = 1'b0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r      <= node_nxt;
    idx_r       <= idx_nxt;
    out_label_r <= out_label_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_new_label      = out_label_r;
  assign out_table_overflow = out_ovf_r;

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_NODES))
    else $error("distinct count beyond table size");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_C_CMP) |-> (idx_r < count_r))
    else $error("probe past table fill");

  a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
    lab_we |=> (count_r == '0))
    else $error("node load did not clear distinct table");

  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !out_valid_r)
    else $error("result pending while sequencer busy");

  a_label_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ovf_r) |-> (out_label_r != '0))
    else $error("zero label without overflow");

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import glrc_pkg::*;

  localparam int NODES    = DEF_MAX_NODES;
  localparam int LABELS   = DEF_MAX_LABELS;
  localparam int FRAC     = DEF_FRAC_BITS;
  localparam int SIG_W    = 16 + FRAC;
  localparam int WIDE_W   = SIG_W + OFF_W;
  localparam int INIT_W   = SIG_W + IDX_W;
  localparam int LIMIT    = 6000000;

  typedef struct packed {
    logic [LABEL_W-1:0] label;
    logic               ovf;
  } label_res_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic [1:0] in_command;
  logic [IDX_W-1:0] in_node_index;
  logic [IDX_W-1:0] in_neighbor_node;
  logic [IDX_W-1:0] in_label_value;
  logic [OFF_W-1:0] in_offset_value;
  logic out_valid;
  logic out_ready;
  logic [LABEL_W-1:0] out_new_label;
  logic out_table_overflow;

  graph_label_refine_compress dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_command(in_command), .in_node_index(in_node_index),
    .in_neighbor_node(in_neighbor_node), .in_label_value(in_label_value),
    .in_offset_value(in_offset_value),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_new_label(out_new_label), .out_table_overflow(out_table_overflow)
  );

  // predictor state
  logic [OFF_W-1:0] offsets [LABELS];
  logic [IDX_W-1:0] labels [NODES];
  logic [SIG_W-1:0] sigs [NODES];
  bit               off_ok [LABELS];
  bit               node_ok [NODES];
  logic [SIG_W-1:0] seen_sigs [$];
  label_res_t       pending_labels [$];

  int  mismatches;
  bit  failed;
  bit  calm;
  longint cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // cycle limit
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic logic [SIG_W-1:0] scaled_offset(logic [OFF_W-1:0] raw);
    logic [WIDE_W-1:0] wide;
    wide = WIDE_W'(raw);
    if (FRAC >= 32) wide = wide << (FRAC - 32);
    else wide = wide >> (32 - FRAC);
    return wide[SIG_W-1:0];
  endfunction

  // update predictor for one accepted beat
  function automatic void refine_step(cmd_t cmd, int node, int nb, int lab,
                                      logic [OFF_W-1:0] off);
    label_res_t r;
    int         hit;
    logic [INIT_W-1:0] init;
    case (cmd)
      CMD_LOAD_OFFSET: begin
        if (node < LABELS) begin
          offsets[node] = off;
          off_ok[node] = 1'b1;
        end
      end
      CMD_LOAD_NODE: begin
        labels[node] = lab[IDX_W-1:0];
        init = INIT_W'(lab[IDX_W-1:0]);
        init = init << FRAC;
        sigs[node] = init[SIG_W-1:0];
        node_ok[node] = 1'b1;
        seen_sigs.delete();
      end
      CMD_EDGE: begin
        if (labels[nb] != 0 && labels[nb] < LABELS)
          sigs[node] = sigs[node] + scaled_offset(offsets[labels[nb]]);
      end
      CMD_COMPRESS: begin
        hit = -1;
        foreach (seen_sigs[i])
          if (hit < 0 && seen_sigs[i] == sigs[node]) hit = i;
        if (hit >= 0) begin
          r.label = LABEL_W'(hit + 1);
          r.ovf = 1'b0;
        end else if (seen_sigs.size() < NODES) begin
          seen_sigs.push_back(sigs[node]);
          r.label = LABEL_W'(seen_sigs.size());
          r.ovf = 1'b0;
        end else begin
          r.label = '0;
          r.ovf = 1'b1;
        end
        pending_labels.push_back(r);
      end
      default: begin
      end
    endcase
  endfunction

  // send one beat; called at a rising edge
  task automatic send_item(cmd_t cmd, int node, int nb, int lab, logic [OFF_W-1:0] off);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_command       <= cmd;
    in_node_index    <= node[IDX_W-1:0];
    in_neighbor_node <= nb[IDX_W-1:0];
    in_label_value   <= lab[IDX_W-1:0];
    in_offset_value  <= off;
    do @(posedge clk); while (!in_ready);
    refine_step(cmd, node, nb, lab, off);
  endtask

  // sender idles until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_labels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // pick a loaded node, mostly from the low pool
  function automatic int pick_node();
    int n;
    for (int t = 0; t < 40; t++) begin
      n = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 31) : $urandom_range(0, NODES - 1);
      if (node_ok[n]) return n;
    end
    return 0;
  endfunction

  // a source whose label offset is defined
  function automatic int pick_source();
    int n;
    for (int t = 0; t < 40; t++) begin
      n = pick_node();
      if (labels[n] == 0 || off_ok[labels[n]]) return n;
    end
    return 0;
  endfunction

  // result side backpressure
  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = calm ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result checker
  always @(posedge clk) begin
    label_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_labels.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: label %0d ovf %0b", out_new_label, out_table_overflow);
      end else begin
        e = pending_labels.pop_front();
        if (out_new_label !== e.label || out_table_overflow !== e.ovf) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected label %0d ovf %0b, got label %0d ovf %0b",
                     e.label, e.ovf, out_new_label, out_table_overflow);
        end
      end
    end
  end

  // extremes, each command, zero label, repeated signatures
  task automatic test_directed();
    send_item(CMD_LOAD_OFFSET, 1, 0, 0, 32'h0000_0001);
    send_item(CMD_LOAD_OFFSET, 2, 0, 0, 32'hFFFF_FFFF);
    send_item(CMD_LOAD_OFFSET, 3, 0, 0, 32'h8000_0000);
    send_item(CMD_LOAD_OFFSET, 1023, 0, 0, 32'hFFFF_FFFF);
    send_item(CMD_LOAD_OFFSET, 0, 0, 0, 32'h1234_5678);
    send_item(CMD_LOAD_NODE, 0, 0, 0, '0);
    send_item(CMD_LOAD_NODE, 1, 0, 1, '0);
    send_item(CMD_LOAD_NODE, 2, 0, 2, '0);
    send_item(CMD_LOAD_NODE, 1023, 0, 1023, '0);
    send_item(CMD_LOAD_NODE, 3, 0, 1023, '0);
    // zero label source adds nothing
    send_item(CMD_EDGE, 1, 0, 0, '0);
    send_item(CMD_COMPRESS, 1, 0, 0, '0);
    send_item(CMD_COMPRESS, 0, 0, 0, '0);
    // top label with the largest offsets added
    send_item(CMD_EDGE, 1023, 1023, 0, '0);
    send_item(CMD_EDGE, 1023, 2, 0, '0);
    send_item(CMD_EDGE, 3, 1023, 0, '0);
    send_item(CMD_COMPRESS, 1023, 0, 0, '0);
    send_item(CMD_COMPRESS, 3, 0, 0, '0);
    send_item(CMD_EDGE, 0, 1, 0, '0);
    send_item(CMD_COMPRESS, 0, 0, 0, '0);
    send_item(CMD_COMPRESS, 1, 0, 0, '0);
    send_item(CMD_COMPRESS, 1023, 0, 0, '0);
    drain();
  endtask

  // random well formed traffic with some noise
  task automatic test_random(int count);
    int k;
    int n;
    for (int i = 0; i < 16; i++)
      send_item(CMD_LOAD_OFFSET, i, $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom());
    for (int i = 0; i < 32; i++)
      send_item(CMD_LOAD_NODE, i, $urandom_range(0, 1023), $urandom_range(0, 7), $urandom());
    for (int i = 0; i < count; i++) begin
      if (i % 400 == 200) calm = 1'b1;
      if (i % 400 == 300) calm = 1'b0;
      if (i == count / 2) drain();
      k = $urandom_range(0, 99);
      if (k < 4) begin
        send_item(CMD_LOAD_OFFSET, $urandom_range(0, 1023), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom());
      end else if (k < 8) begin
        n = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 31) : $urandom_range(0, 1023);
        send_item(CMD_LOAD_NODE, n, $urandom_range(0, 1023),
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15),
                  $urandom());
      end else if (k < 55) begin
        send_item(CMD_EDGE, pick_node(), pick_source(), $urandom_range(0, 1023), $urandom());
      end else begin
        send_item(CMD_COMPRESS, pick_node(), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom());
      end
    end
    drain();
  endtask

  // fill the distinct table, then force an overflow
  task automatic test_table_full();
    calm = 1'b1;
    send_item(CMD_LOAD_OFFSET, 1, 0, 0, 32'h0000_0100);
    for (int i = 0; i < NODES; i++) send_item(CMD_LOAD_NODE, i, 0, i, '0);
    for (int i = 0; i < NODES; i++) send_item(CMD_COMPRESS, i, 0, 0, '0);
    send_item(CMD_EDGE, 0, 1, 0, '0);
    send_item(CMD_COMPRESS, 0, 0, 0, '0);
    send_item(CMD_COMPRESS, 1, 0, 0, '0);
    calm = 1'b0;
    drain();
  endtask

  initial begin
    mismatches = 0;
    failed = 1'b0;
    calm = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_LOAD_OFFSET;
    in_node_index <= '0;
    in_neighbor_node <= '0;
    in_label_value <= '0;
    in_offset_value <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1700);
    test_table_full();
    repeat (50) @(posedge clk);
    if (pending_labels.size() != 0) failed = 1'b1;
    if (!failed) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
